@@ rtl/bill_acceptor_link_controller_unit_assert.svh @@
// assertion macros for the bill acceptor link controller
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef BILL_ACCEPTOR_LINK_CONTROLLER_UNIT_ASSERT_SVH
`define BILL_ACCEPTOR_LINK_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BALC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("balc check failed");

// next-cycle implication, disabled during reset
`define BALC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("balc check failed");

`endif

@@ rtl/balc_pkg.sv @@
// shared types and constants for the bill acceptor link controller
// no dependencies
`timescale 1ns / 1ps

package balc_pkg;

    localparam int FRAME_BYTES_DEF = 4;

    // event codes
    localparam logic [2:0] MODE_BYTE  = 3'd0;
    localparam logic [2:0] MODE_TICK  = 3'd1;
    localparam logic [2:0] MODE_START = 3'd2;
    localparam logic [2:0] MODE_STOP  = 3'd3;
    localparam logic [2:0] MODE_TAKE  = 3'd4;

    // phase codes as reported on phase_now
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_POWERUP   = 3'd1;
    localparam logic [2:0] PH_POLL      = 3'd2;
    localparam logic [2:0] PH_ESCROW    = 3'd3;
    localparam logic [2:0] PH_ACK       = 3'd4;
    localparam logic [2:0] PH_WAIT_READ = 3'd5;
    localparam logic [2:0] PH_STOPPED   = 3'd6;

    // register indexes
    localparam logic [2:0] CFG_POWERUP_WAIT = 3'd0;
    localparam logic [2:0] CFG_ESCROW_TMO   = 3'd1;
    localparam logic [2:0] CFG_VALUE_LOW    = 3'd2;
    localparam logic [2:0] CFG_VALUE_MID    = 3'd3;
    localparam logic [2:0] CFG_VALUE_HIGH   = 3'd4;

    // link bytes
    localparam logic [7:0] HDR_POWERUP   = 8'h80;
    localparam logic [7:0] PWR_OK        = 8'h8F;
    localparam logic [7:0] HDR_POLL      = 8'h81;
    localparam logic [7:0] CODE_LOW      = 8'h40;
    localparam logic [7:0] CODE_MID      = 8'h41;
    localparam logic [7:0] CODE_HIGH     = 8'h42;
    localparam logic [7:0] ESC_STACKED   = 8'h10;
    localparam logic [7:0] ESC_RETURNED  = 8'h11;
    localparam logic [7:0] STAT_STACKED  = 8'h2A;
    localparam logic [7:0] STATUS_LO     = 8'h20;
    localparam logic [7:0] STATUS_HI     = 8'h2F;
    localparam logic [7:0] TX_ACK        = 8'h02;
    localparam logic [7:0] TX_REJECT     = 8'h0F;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] rx_byte;
    } t_in_req;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [15:0] bill_value;
        logic [2:0]  phase_now;
    } t_out_req;

    typedef struct packed {
        logic [15:0] powerup_wait_ticks;
        logic [15:0] escrow_timeout_ticks;
        logic [15:0] bill_value_low;
        logic [15:0] bill_value_mid;
        logic [15:0] bill_value_high;
    } t_cfg;

    // frame update commands from the sequencer
    typedef struct packed {
        logic clear;
        logic rewind;
        logic write;
    } t_frame_ctl;

endpackage

@@ rtl/balc_cfg.sv @@
// configuration register file for the bill acceptor link controller
// depends on balc_pkg
`timescale 1ns / 1ps

module balc_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_wdata,
    output balc_pkg::t_cfg    o_cfg
);
    import balc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.powerup_wait_ticks   <= 16'd50;
            r_cfg.escrow_timeout_ticks <= 16'd100;
            r_cfg.bill_value_low       <= 16'd20;
            r_cfg.bill_value_mid       <= 16'd50;
            r_cfg.bill_value_high      <= 16'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POWERUP_WAIT: r_cfg.powerup_wait_ticks   <= i_cfg_wdata;
                CFG_ESCROW_TMO:   r_cfg.escrow_timeout_ticks <= i_cfg_wdata;
                CFG_VALUE_LOW:    r_cfg.bill_value_low       <= i_cfg_wdata;
                CFG_VALUE_MID:    r_cfg.bill_value_mid       <= i_cfg_wdata;
                CFG_VALUE_HIGH:   r_cfg.bill_value_high      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/balc_frame.sv @@
// receive frame buffer with write position
// depends on balc_pkg
`timescale 1ns / 1ps

module balc_frame #(
    parameter int FRAME_BYTES = balc_pkg::FRAME_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  balc_pkg::t_frame_ctl   i_ctl,
    input  logic [7:0]             i_byte,
    output logic [7:0]             o_byte0,
    output logic [7:0]             o_byte1
);
    import balc_pkg::*;

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BYTES - 1);

    logic [7:0]       r_frame [FRAME_BYTES];
    logic [7:0]       n_frame [FRAME_BYTES];
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] wr_idx;

    always_comb begin
        n_frame = r_frame;
        n_idx   = r_idx;
        wr_idx  = r_idx;
        if (i_step) begin
            if (i_ctl.clear) begin
                for (int k = 0; k < FRAME_BYTES; k++) begin
                    n_frame[k] = 8'h00;
                end
                n_idx = '0;
            end
            if (i_ctl.rewind) begin
                n_idx = '0;
            end
            wr_idx = n_idx;
            if (i_ctl.write) begin
                n_frame[wr_idx] = i_byte;
                n_idx = (wr_idx == IDX_LAST) ? '0 : wr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRAME_BYTES; k++) begin
                r_frame[k] <= 8'h00;
            end
            r_idx <= '0;
        end else begin
            r_frame <= n_frame;
            r_idx   <= n_idx;
        end
    end

    assign o_byte0 = r_frame[0];
    assign o_byte1 = r_frame[1];

endmodule

@@ rtl/balc_seq.sv @@
// link sequencer: phase, tick counter, held bill and per-request result
// depends on balc_pkg
`timescale 1ns / 1ps

module balc_seq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  balc_pkg::t_in_req      i_req,
    input  balc_pkg::t_cfg         i_cfg,
    input  logic [7:0]             i_frame0,
    input  logic [7:0]             i_frame1,
    output balc_pkg::t_frame_ctl   o_frame_ctl,
    output balc_pkg::t_out_req     o_result
);
    import balc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE      = PH_IDLE,
        ST_POWERUP   = PH_POWERUP,
        ST_POLL      = PH_POLL,
        ST_ESCROW    = PH_ESCROW,
        ST_ACK       = PH_ACK,
        ST_WAIT_READ = PH_WAIT_READ,
        ST_STOPPED   = PH_STOPPED
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_running, n_running;
    logic [15:0] r_tick, n_tick;
    logic [15:0] r_held, n_held;
    logic [15:0] tick_inc;
    logic        rx_header;
    logic        rx_status;
    logic        f0_status;
    t_frame_ctl  ctl;
    t_out_req    res;

    assign tick_inc  = (r_tick == TICK_MAX) ? r_tick : r_tick + 16'd1;
    assign rx_status = i_req.rx_byte inside {[STATUS_LO:STATUS_HI]};
    assign f0_status = i_frame0 inside {[STATUS_LO:STATUS_HI]};

    always_comb begin
        case (r_phase)
            ST_POWERUP: rx_header = (i_req.rx_byte == HDR_POWERUP);
            ST_POLL:    rx_header = (i_req.rx_byte == HDR_POLL);
            ST_ESCROW:  rx_header = (i_req.rx_byte == ESC_STACKED)
                                 || (i_req.rx_byte == ESC_RETURNED);
            default:    rx_header = 1'b0;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_running = r_running;
        n_tick    = r_tick;
        n_held    = r_held;
        ctl       = '0;
        res       = '0;
        case (i_req.mode)
            MODE_BYTE: begin
                if (r_phase == ST_POWERUP || r_phase == ST_POLL || r_phase == ST_ESCROW) begin
                    ctl.write = 1'b1;
                    ctl.clear = rx_header || rx_status;
                end
            end
            MODE_TICK: begin
                if (r_running) begin
                    n_tick = tick_inc;
                    case (r_phase)
                        ST_POWERUP: begin
                            if (tick_inc >= i_cfg.powerup_wait_ticks) begin
                                n_tick = '0;
                                if (i_frame0 == HDR_POWERUP && i_frame1 == PWR_OK) begin
                                    n_phase = ST_ACK;
                                end
                            end
                        end
                        ST_ACK: begin
                            if (tick_inc >= i_cfg.powerup_wait_ticks) begin
                                n_tick       = '0;
                                n_phase      = ST_POLL;
                                res.tx_valid = 1'b1;
                                res.tx_byte  = TX_ACK;
                            end
                        end
                        ST_POLL: begin
                            if (i_frame0 == HDR_POLL) begin
                                if (i_frame1 inside {[CODE_LOW:CODE_HIGH]}) begin
                                    n_tick       = '0;
                                    n_phase      = ST_ESCROW;
                                    res.tx_valid = 1'b1;
                                    res.tx_byte  = TX_ACK;
                                    case (i_frame1)
                                        CODE_LOW: n_held = i_cfg.bill_value_low;
                                        CODE_MID: n_held = i_cfg.bill_value_mid;
                                        default:  n_held = i_cfg.bill_value_high;
                                    endcase
                                end else if (tick_inc >= i_cfg.escrow_timeout_ticks) begin
                                    ctl.clear    = 1'b1;
                                    n_tick       = '0;
                                    n_phase      = ST_ESCROW;
                                    res.tx_valid = 1'b1;
                                    res.tx_byte  = TX_REJECT;
                                end
                            end
                        end
                        ST_ESCROW: begin
                            if (i_frame0 == ESC_STACKED || i_frame0 == STAT_STACKED) begin
                                n_tick  = '0;
                                n_phase = ST_WAIT_READ;
                            end else if (i_frame0 == ESC_RETURNED || f0_status) begin
                                ctl.clear = 1'b1;
                                n_tick    = '0;
                                n_held    = '0;
                                n_phase   = ST_POLL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            MODE_START: begin
                ctl.clear = 1'b1;
                n_tick    = '0;
                n_running = 1'b1;
                n_phase   = ST_POWERUP;
            end
            MODE_STOP: begin
                ctl.clear = 1'b1;
                n_tick    = '0;
                n_running = 1'b0;
                n_phase   = ST_STOPPED;
            end
            MODE_TAKE: begin
                if (r_phase == ST_WAIT_READ) begin
                    res.bill_value = r_held;
                    n_held         = '0;
                    ctl.rewind     = 1'b1;
                    n_tick         = '0;
                    n_phase        = ST_POLL;
                end
            end
            default: begin
            end
        endcase
        res.phase_now = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ST_IDLE;
            r_running <= 1'b0;
            r_tick    <= '0;
            r_held    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_running <= n_running;
            r_tick    <= n_tick;
            r_held    <= n_held;
        end
    end

    assign o_frame_ctl = ctl;
    assign o_result    = res;

endmodule

@@ rtl/bill_acceptor_link_controller_unit.sv @@
// path: an accepted request waits in the input reg, then its result in the result reg
// throughput: one request per cycle while the result side is ready; the state update
// sets the rate, and the request register can take one new request while a result waits
// reset: synchronous active-low; phase idle, not running, frame cleared,
// registers back to defaults (wait 50, timeout 100, values 20/50/100)
`timescale 1ns / 1ps
`include "bill_acceptor_link_controller_unit_assert.svh"

module bill_acceptor_link_controller_unit #(
    parameter int FRAME_BYTES = balc_pkg::FRAME_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  balc_pkg::t_in_req    i_in_req,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output balc_pkg::t_out_req   o_out_req,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_wdata
);
    import balc_pkg::*;

    // request holding register
    logic       r_in_valid;
    t_in_req    r_in;
    // result register
    logic       r_out_valid;
    t_out_req   r_out;

    logic       step;        // request moves from input reg through the sequencer
    t_cfg       cfg;
    t_frame_ctl frame_ctl;
    t_out_req   result;
    logic [7:0] frame0;
    logic [7:0] frame1;

    // a request advances when the result register is empty or being drained
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    balc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // frame buffer: bytes received from the acceptor
    balc_frame #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_ctl   (frame_ctl),
        .i_byte  (r_in.rx_byte),
        .o_byte0 (frame0),
        .o_byte1 (frame1)
    );

    // sequencer: phase machine and result formation
    balc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_req       (r_in),
        .i_cfg       (cfg),
        .i_frame0    (frame0),
        .i_frame1    (frame1),
        .o_frame_ctl (frame_ctl),
        .o_result    (result)
    );

    // a sent byte is only ever ack or reject
    `BALC_ASSERT_SAME(a_tx_byte_code, r_out_valid && r_out.tx_valid,
        r_out.tx_byte == TX_ACK || r_out.tx_byte == TX_REJECT)
    // a sent byte leaves the link in poll or escrow
    `BALC_ASSERT_SAME(a_tx_phase, r_out_valid && r_out.tx_valid,
        r_out.phase_now == PH_POLL || r_out.phase_now == PH_ESCROW)
    // a paid-out bill always re-arms polling
    `BALC_ASSERT_SAME(a_take_phase, r_out_valid && (r_out.bill_value != 16'd0),
        r_out.phase_now == PH_POLL)
    // an advancing request always lands in the result register
    `BALC_ASSERT_NEXT(a_step_fills, step, r_out_valid)

endmodule

@@ tb/bill_acceptor_link_controller_unit_tb.sv @@
// self-checking testbench for the bill acceptor link controller
// depends on balc_pkg and bill_acceptor_link_controller_unit
`timescale 1ns / 1ps

module bill_acceptor_link_controller_unit_tb;

    import balc_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_REQUESTS  = 220;
    localparam int PRESSURE_AT     = 400;
    localparam int PRESSURE_CYCLES = 300;
    localparam int SHOWN_FAILURES  = 10;

    // event codes the block must ignore
    localparam logic [2:0] MODE_SPARE = 3'd5;
    // first register index past the end of the map
    localparam logic [2:0] CFG_SPARE  = 3'd5;

    // one row of the directed script; want is used only when typed is set
    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_req want;
    } t_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_in_req  i_in_req = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_out_req o_out_req;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_wdata = '0;

    // shadow copy of the link state, advanced once per accepted request
    t_cfg        lk_cfg;
    logic [2:0]  lk_phase;
    logic        lk_running;
    logic [7:0]  lk_frame [FRAME_BYTES_DEF];
    int          lk_fidx;
    logic [15:0] lk_ticks;
    logic [15:0] lk_held;

    t_out_req    awaited_replies [$];
    t_row        script_rows [$];
    bit          no_gaps = 1'b0;
    int unsigned replies_seen = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    always #6 i_clk = ~i_clk;

    bill_acceptor_link_controller_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // link predictor
    // ------------------------------------------------------------------

    function automatic bit is_status_byte(logic [7:0] c);
        return (c >= STATUS_LO) && (c <= STATUS_HI);
    endfunction

    function automatic void clear_frame();
        for (int i = 0; i < FRAME_BYTES_DEF; i++) begin
            lk_frame[i] = '0;
        end
        lk_fidx = 0;
    endfunction

    // apply one request to the shadow state and return the reply it causes
    function automatic t_out_req advance_link(t_in_req r);
        t_out_req   res;
        bit         hdr;
        bit         listening;
        logic [7:0] code;
        res = '0;
        case (r.mode)
            MODE_BYTE: begin
                // only powerup, poll and escrow collect bytes
                listening = (lk_phase == PH_POWERUP) || (lk_phase == PH_POLL) ||
                            (lk_phase == PH_ESCROW);
                hdr = (lk_phase == PH_POWERUP && r.rx_byte == HDR_POWERUP) ||
                      (lk_phase == PH_POLL && r.rx_byte == HDR_POLL) ||
                      (lk_phase == PH_ESCROW &&
                       (r.rx_byte == ESC_STACKED || r.rx_byte == ESC_RETURNED));
                if (listening) begin
                    if (hdr || is_status_byte(r.rx_byte)) begin
                        clear_frame();
                    end
                    lk_frame[lk_fidx] = r.rx_byte;
                    lk_fidx = (lk_fidx + 1) % FRAME_BYTES_DEF;
                end
            end
            MODE_TICK: begin
                if (lk_running) begin
                    if (lk_ticks != TICK_MAX) begin
                        lk_ticks = lk_ticks + 16'd1;
                    end
                    case (lk_phase)
                        PH_POWERUP: begin
                            if (lk_ticks >= lk_cfg.powerup_wait_ticks) begin
                                lk_ticks = '0;
                                if (lk_frame[0] == HDR_POWERUP && lk_frame[1] == PWR_OK) begin
                                    lk_phase = PH_ACK;
                                end
                            end
                        end
                        PH_ACK: begin
                            if (lk_ticks >= lk_cfg.powerup_wait_ticks) begin
                                lk_ticks = '0;
                                lk_phase = PH_POLL;
                                res.tx_valid = 1'b1;
                                res.tx_byte = TX_ACK;
                            end
                        end
                        PH_POLL: begin
                            // no poll header held: wait; ticks still count but the timeout cannot fire
                            if (lk_frame[0] == HDR_POLL) begin
                                code = lk_frame[1];
                                if (code >= CODE_LOW && code <= CODE_HIGH) begin
                                    lk_ticks = '0;
                                    lk_phase = PH_ESCROW;
                                    lk_held = (code == CODE_LOW) ? lk_cfg.bill_value_low :
                                              (code == CODE_MID) ? lk_cfg.bill_value_mid :
                                                                   lk_cfg.bill_value_high;
                                    res.tx_valid = 1'b1;
                                    res.tx_byte = TX_ACK;
                                end else if (lk_ticks >= lk_cfg.escrow_timeout_ticks) begin
                                    clear_frame();
                                    lk_ticks = '0;
                                    lk_phase = PH_ESCROW;
                                    res.tx_valid = 1'b1;
                                    res.tx_byte = TX_REJECT;
                                end
                            end
                        end
                        PH_ESCROW: begin
                            if (lk_frame[0] == ESC_STACKED || lk_frame[0] == STAT_STACKED) begin
                                lk_ticks = '0;
                                lk_phase = PH_WAIT_READ;
                            end else if (lk_frame[0] == ESC_RETURNED ||
                                         is_status_byte(lk_frame[0])) begin
                                clear_frame();
                                lk_ticks = '0;
                                lk_held = '0;
                                lk_phase = PH_POLL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            MODE_START, MODE_STOP: begin
                clear_frame();
                lk_ticks = '0;
                lk_running = (r.mode == MODE_START);
                lk_phase = (r.mode == MODE_START) ? PH_POWERUP : PH_STOPPED;
            end
            MODE_TAKE: begin
                // frame contents survive, only the write position rewinds
                if (lk_phase == PH_WAIT_READ) begin
                    res.bill_value = lk_held;
                    lk_held = '0;
                    lk_fidx = 0;
                    lk_ticks = '0;
                    lk_phase = PH_POLL;
                end
            end
            default: begin
            end
        endcase
        res.phase_now = lk_phase;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_in_req make_req(logic [2:0] m, logic [7:0] b);
        t_in_req r;
        r.mode = m;
        r.rx_byte = b;
        return r;
    endfunction

    function automatic void add_row(logic [2:0] m, logic [7:0] b, bit typed, t_out_req w);
        t_row row;
        row.req = make_req(m, b);
        row.typed = typed;
        row.want = w;
        script_rows.push_back(row);
    endfunction

    // choose the next request from the predicted phase so that most traffic
    // walks the full session; the rest is noise and broken sequences
    function automatic t_in_req pick_request();
        int unsigned r;
        logic [7:0]  any_byte;
        logic [7:0]  f0;
        r = $urandom_range(0, 99);
        any_byte = 8'($urandom_range(0, 255));
        f0 = lk_frame[0];
        if (r < 4) begin
            return make_req(3'($urandom_range(0, 7)), any_byte);
        end
        if (r < 6) begin
            return make_req(($urandom_range(0, 1) == 0) ? MODE_START : MODE_STOP, any_byte);
        end
        r = $urandom_range(0, 99);
        case (lk_phase)
            PH_POWERUP: begin
                if (f0 != HDR_POWERUP) begin
                    if (r < 75) return make_req(MODE_BYTE, HDR_POWERUP);
                    if (r < 90) return make_req(MODE_TICK, any_byte);
                    return make_req(MODE_BYTE, any_byte);
                end
                if (lk_fidx == 1) begin
                    if (r < 80) return make_req(MODE_BYTE, PWR_OK);
                    return make_req(MODE_BYTE, any_byte);
                end
                if (r < 85) return make_req(MODE_TICK, any_byte);
                return make_req(MODE_BYTE, any_byte);
            end
            PH_ACK: begin
                if (r < 90) return make_req(MODE_TICK, any_byte);
                if (r < 95) return make_req(MODE_TAKE, any_byte);
                return make_req(MODE_BYTE, any_byte);
            end
            PH_POLL: begin
                if (f0 != HDR_POLL) begin
                    if (r < 70) return make_req(MODE_BYTE, HDR_POLL);
                    if (r < 85) return make_req(MODE_TICK, any_byte);
                    return make_req(MODE_BYTE, any_byte);
                end
                if (lk_fidx == 1) begin
                    if (r < 70) return make_req(MODE_BYTE, CODE_LOW + 8'($urandom_range(0, 2)));
                    if (r < 90) return make_req(MODE_BYTE, any_byte);
                    return make_req(MODE_TICK, any_byte);
                end
                if (r < 85) return make_req(MODE_TICK, any_byte);
                return make_req(MODE_BYTE, any_byte);
            end
            PH_ESCROW: begin
                if (f0 == ESC_STACKED || f0 == STAT_STACKED || f0 == ESC_RETURNED ||
                    is_status_byte(f0)) begin
                    if (r < 85) return make_req(MODE_TICK, any_byte);
                    return make_req(MODE_BYTE, any_byte);
                end
                if (r < 30) return make_req(MODE_BYTE, ESC_STACKED);
                if (r < 50) return make_req(MODE_BYTE, ESC_RETURNED);
                if (r < 60) return make_req(MODE_BYTE, STAT_STACKED);
                if (r < 72) return make_req(MODE_BYTE, STATUS_LO + 8'($urandom_range(0, 15)));
                if (r < 82) return make_req(MODE_BYTE, any_byte);
                return make_req(MODE_TICK, any_byte);
            end
            PH_WAIT_READ: begin
                if (r < 75) return make_req(MODE_TAKE, any_byte);
                if (r < 90) return make_req(MODE_TICK, any_byte);
                return make_req(MODE_BYTE, any_byte);
            end
            default: begin
                // idle or stopped: mostly start a new session
                if (r < 85) return make_req(MODE_START, any_byte);
                return make_req(3'($urandom_range(0, 7)), any_byte);
            end
        endcase
    endfunction

    // offer one request, hold it until accepted, then queue its reply
    task automatic offer(t_in_req r, bit typed, t_out_req typed_want);
        int       gap;
        t_out_req predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= r;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = advance_link(r);
        awaited_replies.push_back(typed ? typed_want : predicted);
    endtask

    // let every reply drain so the block is idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write all five registers plus one index past the map, back to back
    task automatic program_regs(logic [15:0] pw, logic [15:0] tmo,
                                logic [15:0] lo, logic [15:0] mid, logic [15:0] hi);
        logic [2:0]  idx [6];
        logic [15:0] val [6];
        idx = '{CFG_POWERUP_WAIT, CFG_ESCROW_TMO, CFG_VALUE_LOW, CFG_VALUE_MID,
                CFG_VALUE_HIGH, CFG_SPARE + 3'($urandom_range(0, 2))};
        val = '{pw, tmo, lo, mid, hi, 16'($urandom_range(0, 65535))};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_wdata <= val[i];
            @(posedge i_clk);
            case (idx[i])
                CFG_POWERUP_WAIT: lk_cfg.powerup_wait_ticks = val[i];
                CFG_ESCROW_TMO:   lk_cfg.escrow_timeout_ticks = val[i];
                CFG_VALUE_LOW:    lk_cfg.bill_value_low = val[i];
                CFG_VALUE_MID:    lk_cfg.bill_value_mid = val[i];
                CFG_VALUE_HIGH:   lk_cfg.bill_value_high = val[i];
                default: begin
                end
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic void note_failure(string what, logic [15:0] want, logic [15:0] got);
        fail_count++;
        if (fail_count <= SHOWN_FAILURES) begin
            $display("reply %0d: %s expected %h got %h", replies_seen, what, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // reply side: random back-pressure, one long hold-off, field checks
    // ------------------------------------------------------------------

    initial begin
        int       stall;
        bit       pressure_done;
        t_out_req want;
        t_out_req got;
        pressure_done = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 11);
            // long hold-off so the request side backs up and stalls
            if (!pressure_done && replies_seen >= PRESSURE_AT) begin
                stall = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got = o_out_req;
            if (awaited_replies.size() == 0) begin
                note_failure("unexpected reply, phase_now", '0, 16'(got.phase_now));
            end else begin
                want = awaited_replies.pop_front();
                if (got.tx_valid !== want.tx_valid)
                    note_failure("tx_valid", 16'(want.tx_valid), 16'(got.tx_valid));
                if (got.tx_byte !== want.tx_byte)
                    note_failure("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
                if (got.bill_value !== want.bill_value)
                    note_failure("bill_value", want.bill_value, got.bill_value);
                if (got.phase_now !== want.phase_now)
                    note_failure("phase_now", 16'(want.phase_now), 16'(got.phase_now));
            end
            replies_seen++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bill_acceptor_link_controller_unit_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        logic [15:0] pw;
        logic [15:0] tmo;
        logic [15:0] lo;
        logic [15:0] mid;
        logic [15:0] hi;

        // shadow state at reset
        lk_cfg.powerup_wait_ticks = 16'd50;
        lk_cfg.escrow_timeout_ticks = 16'd100;
        lk_cfg.bill_value_low = 16'd20;
        lk_cfg.bill_value_mid = 16'd50;
        lk_cfg.bill_value_high = 16'd100;
        lk_phase = PH_IDLE;
        lk_running = 1'b0;
        clear_frame();
        lk_ticks = '0;
        lk_held = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short waits so the directed session runs in a few requests
        program_regs(16'd1, 16'd2, 16'h0000, 16'hFFFF, 16'h1234);

        // directed session: quiet idle, full accept path, reject on timeout,
        // status byte back to poll, stop
        add_row(MODE_TAKE,  8'h00, 1, {1'b0, 8'h00, 16'h0000, PH_IDLE});
        add_row(MODE_TICK,  8'hFF, 1, {1'b0, 8'h00, 16'h0000, PH_IDLE});
        add_row(MODE_BYTE,  HDR_POWERUP, 1, {1'b0, 8'h00, 16'h0000, PH_IDLE});
        add_row(MODE_SPARE, 8'hFF, 1, {1'b0, 8'h00, 16'h0000, PH_IDLE});
        add_row(MODE_START, 8'h00, 1, {1'b0, 8'h00, 16'h0000, PH_POWERUP});
        add_row(MODE_BYTE,  8'h00, 0, '0);
        add_row(MODE_BYTE,  HDR_POWERUP, 0, '0);
        add_row(MODE_BYTE,  PWR_OK, 0, '0);
        add_row(MODE_TICK,  8'h00, 1, {1'b0, 8'h00, 16'h0000, PH_ACK});
        add_row(MODE_BYTE,  8'hFF, 0, '0);
        add_row(MODE_TICK,  8'h00, 1, {1'b1, TX_ACK, 16'h0000, PH_POLL});
        add_row(MODE_BYTE,  HDR_POLL, 0, '0);
        add_row(MODE_BYTE,  CODE_MID, 0, '0);
        add_row(MODE_TICK,  8'h00, 1, {1'b1, TX_ACK, 16'h0000, PH_ESCROW});
        add_row(MODE_BYTE,  ESC_STACKED, 0, '0);
        add_row(MODE_TICK,  8'h00, 1, {1'b0, 8'h00, 16'h0000, PH_WAIT_READ});
        add_row(MODE_TAKE,  8'h00, 1, {1'b0, 8'h00, 16'hFFFF, PH_POLL});
        add_row(MODE_TAKE,  8'h00, 1, {1'b0, 8'h00, 16'h0000, PH_POLL});
        add_row(MODE_BYTE,  HDR_POLL, 0, '0);
        add_row(MODE_BYTE,  8'h33, 0, '0);
        add_row(MODE_TICK,  8'h00, 0, '0);
        add_row(MODE_TICK,  8'h00, 1, {1'b1, TX_REJECT, 16'h0000, PH_ESCROW});
        add_row(MODE_BYTE,  STATUS_LO + 8'h05, 0, '0);
        add_row(MODE_TICK,  8'h00, 1, {1'b0, 8'h00, 16'h0000, PH_POLL});
        add_row(MODE_STOP,  8'h00, 1, {1'b0, 8'h00, 16'h0000, PH_STOPPED});
        add_row(MODE_TICK,  8'h00, 0, '0);

        foreach (script_rows[i]) begin
            offer(script_rows[i].req, script_rows[i].typed, script_rows[i].want);
        end
        settle();

        // random sessions under several register settings, extremes included
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pw  = (p == 0) ? 16'h0000 : (p == RANDOM_PHASES - 1) ? 16'hFFFF :
                  16'($urandom_range(0, 4));
            tmo = (p == 1) ? 16'h0000 : (p == 3) ? 16'hFFFF : 16'($urandom_range(0, 12));
            lo  = (p == 0) ? 16'h0000 : (p == 2) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            mid = (p == 0) ? 16'h0000 : (p == 2) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            hi  = (p == 0) ? 16'h0000 : (p == 2) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            program_regs(pw, tmo, lo, mid, hi);
            // every third phase runs back to back on both sides
            no_gaps = (p % 3 == 1);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                offer(pick_request(), 0, '0);
            end
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("bill_acceptor_link_controller_unit_tb OK");
        end else begin
            $display("bill_acceptor_link_controller_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
